FILE: rtl/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants
// Operation codes, controller/datapath status, register indexes and the
// CORDIC arctangent table for the odometry and goal-seek block.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam logic [35:0] CORDIC_GAIN_Q30 = 36'd652032874;
	localparam logic [32:0] TWO_PI_Q12 = 33'd25736;

	typedef enum logic [2:0] {
		CFG_DIST_PER_TICK = 3'd0,
		CFG_ANGLE_PER_CM  = 3'd1,
		CFG_KP_ANGLE      = 3'd2,
		CFG_BASE_SPEED    = 3'd3,
		CFG_ARRIVE_RADIUS = 3'd4,
		CFG_GOAL_COUNT    = 3'd5,
		CFG_GOAL_X_TABLE  = 3'd6,
		CFG_GOAL_Y_TABLE  = 3'd7
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_S,
		OP_MUL_D,
		OP_MUL_A,
		OP_ANGLE,
		OP_MUL_X,
		OP_MUL_Y,
		OP_POSY,
		OP_GOAL,
		OP_MUL_EX,
		OP_MUL_EY,
		OP_MUL_R,
		OP_CMP,
		OP_ERR,
		OP_MUL_T,
		OP_TURN,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic no_goal;
		logic reached;
		logic out_free;
	} status_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_angle(input logic [4:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: rtl/ddo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic: iterative CORDIC unit
// One micro-rotation per cycle. Rotation mode gives cos/sin (Q2.30) of a
// binary angle; vectoring mode gives atan2 as a binary angle.
// ----------------------------------------------------------------------------
module ddo_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               vec,
	input  logic [31:0]        angle,
	input  logic signed [32:0] x_in,
	input  logic signed [32:0] y_in,
	output logic               done,
	output logic signed [35:0] x_out,
	output logic signed [35:0] y_out,
	output logic [31:0]        z_out
);

	logic signed [35:0] x_q, y_q, tx, ty;
	logic signed [33:0] z_q, at;
	logic [4:0]         i_q;
	logic               busy_q, fin_q, flip_q, vec_q, done_q;
	logic               up, flip_in;
	logic [31:0]        a_adj;

	assign flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
	assign a_adj   = flip_in ? (angle ^ 32'h8000_0000) : angle;
	assign tx      = y_q >>> i_q;
	assign ty      = x_q >>> i_q;
	assign at      = $signed({2'b00, ddo_pkg::atan_angle(i_q)});
	assign up      = vec_q ? y_q[35] : !z_q[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					i_q <= i_q + 5'd1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= vec;
			if (vec) begin
				flip_q <= 1'b0;
				if (x_in[32]) begin
					x_q <= -36'(x_in);
					y_q <= -36'(y_in);
					z_q <= 34'sh0_8000_0000;
				end else begin
					x_q <= 36'(x_in);
					y_q <= 36'(y_in);
					z_q <= '0;
				end
			end else begin
				flip_q <= flip_in;
				x_q    <= $signed(ddo_pkg::CORDIC_GAIN_Q30);
				y_q    <= '0;
				z_q    <= 34'(signed'(a_adj));
			end
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q - tx;
				y_q <= y_q + ty;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + tx;
				y_q <= y_q - ty;
				z_q <= z_q + at;
			end
		end else if (fin_q && flip_q && !vec_q) begin
			// undo the half-turn taken to bring the angle into range
			x_q <= -x_q;
			y_q <= -y_q;
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q[31:0];

endmodule

FILE: rtl/ddo_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_datapath: pose, steering and result registers
// Config registers, one shared registered multiplier, the CORDIC unit and
// the output register. Acts on the operation code from the controller.
// ----------------------------------------------------------------------------
module ddo_datapath #(
	parameter int GOAL_SLOTS   = 4,
	parameter int CORDIC_STEPS = 16,
	parameter int SPEED_LIMIT  = 400
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ddo_pkg::cmd_t    cmd,
	output ddo_pkg::status_t status,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic [31:0]      in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [127:0]     out_data
);

	// configuration
	logic [23:0] dpt_q;
	logic [31:0] apc_q;
	logic [15:0] kp_q;
	logic [9:0]  base_q;
	logic [15:0] radius_q;
	logic [2:0]  goal_count_q;
	logic [63:0] goal_x_q, goal_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q        <= 24'd185406;
			apc_q        <= 32'd80419640;
			kp_q         <= 16'd7680;
			base_q       <= 10'd75;
			radius_q     <= 16'd256;
			goal_count_q <= 3'd3;
			goal_x_q     <= 64'd125832960;
			goal_y_q     <= 64'd503320320;
		end else if (cfg_we) begin
			unique case (ddo_pkg::cfg_idx_t'(cfg_index))
				ddo_pkg::CFG_DIST_PER_TICK: dpt_q        <= cfg_data[23:0];
				ddo_pkg::CFG_ANGLE_PER_CM:  apc_q        <= cfg_data[31:0];
				ddo_pkg::CFG_KP_ANGLE:      kp_q         <= cfg_data[15:0];
				ddo_pkg::CFG_BASE_SPEED:    base_q       <= cfg_data[9:0];
				ddo_pkg::CFG_ARRIVE_RADIUS: radius_q     <= cfg_data[15:0];
				ddo_pkg::CFG_GOAL_COUNT:    goal_count_q <= cfg_data[2:0];
				ddo_pkg::CFG_GOAL_X_TABLE:  goal_x_q     <= cfg_data;
				ddo_pkg::CFG_GOAL_Y_TABLE:  goal_y_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// working registers
	logic [15:0]        last_l_q, last_r_q;
	logic [31:0]        pos_x_q, pos_y_q, heading_q;
	logic [2:0]         goal_q;
	logic [16:0]        smag_q, dmag_q;
	logic               sneg_q, dneg_q, eneg_q;
	logic signed [32:0] ds_q, ex_q, ey_q;
	logic signed [65:0] prod_q;
	logic [50:0]        d2_q;
	logic [31:0]        em_q;
	logic [9:0]         lsp_q, rsp_q;
	logic               reached_q, done_q;
	logic               out_valid_q;
	logic [127:0]       out_q;

	ddo_pkg::op_t op;
	assign op = cmd.op;

	// encoder deltas
	logic signed [16:0] dl, dr, sum, dif;
	assign dl  = 17'(signed'(in_data[15:0] - last_l_q));
	assign dr  = 17'(signed'(in_data[31:16] - last_r_q));
	assign sum = dl + dr;
	assign dif = dr - dl;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic               mul_en;
	logic signed [35:0] cx, cy;
	logic [31:0]        cz;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (op)
			ddo_pkg::OP_MUL_S: begin
				mul_a = {16'b0, smag_q};
				mul_b = {9'b0, dpt_q};
			end
			ddo_pkg::OP_MUL_D: begin
				mul_a = {16'b0, dmag_q};
				mul_b = {9'b0, dpt_q};
			end
			ddo_pkg::OP_MUL_A: begin
				mul_a = {1'b0, prod_q[39:8]};
				mul_b = {1'b0, apc_q};
			end
			ddo_pkg::OP_MUL_X: begin
				mul_a = ds_q;
				mul_b = cx[32:0];
			end
			ddo_pkg::OP_MUL_Y: begin
				mul_a = ds_q;
				mul_b = cy[32:0];
			end
			ddo_pkg::OP_MUL_EX: begin
				mul_a = {{8{ex_q[32]}}, ex_q[32:8]};
				mul_b = {{8{ex_q[32]}}, ex_q[32:8]};
			end
			ddo_pkg::OP_MUL_EY: begin
				mul_a = {{8{ey_q[32]}}, ey_q[32:8]};
				mul_b = {{8{ey_q[32]}}, ey_q[32:8]};
			end
			ddo_pkg::OP_MUL_R: begin
				mul_a = {17'b0, radius_q};
				mul_b = {17'b0, radius_q};
			end
			ddo_pkg::OP_CMP: begin
				mul_a = {17'b0, kp_q};
				mul_b = ddo_pkg::TWO_PI_Q12;
			end
			ddo_pkg::OP_MUL_T: begin
				mul_a = {1'b0, em_q};
				mul_b = {2'b0, prod_q[30:0]};
			end
			default: mul_en = 1'b0;
		endcase
	end

	// heading update
	logic [31:0] dth, hth, mid;
	assign dth = dneg_q ? (32'd0 - prod_q[47:16]) : prod_q[47:16];
	assign hth = dneg_q ? (32'd0 - prod_q[48:17]) : prod_q[48:17];
	assign mid = heading_q + hth;

	// goal selection
	logic [2:0]         count, goal_inc;
	logic [15:0]        gx16, gy16;
	logic signed [32:0] gx, gy;
	logic               no_goal, reached;
	assign count    = (goal_count_q > 3'(GOAL_SLOTS)) ? 3'(GOAL_SLOTS) : goal_count_q;
	assign no_goal  = goal_q >= count;
	assign goal_inc = goal_q + 3'd1;
	assign gx16     = goal_x_q[{goal_q[1:0], 4'b0} +: 16];
	assign gy16     = goal_y_q[{goal_q[1:0], 4'b0} +: 16];
	assign gx       = {{8{gx16[15]}}, gx16, 9'b0};
	assign gy       = {{8{gy16[15]}}, gy16, 9'b0};
	assign reached  = 66'(d2_q) <= prod_q;

	// heading error and turn
	logic [31:0]        err;
	logic signed [16:0] turn, base17, lsum, rsum, lim;
	assign err    = cz - heading_q;
	assign turn   = eneg_q ? -17'({6'b0, prod_q[62:52]}) : 17'({6'b0, prod_q[62:52]});
	assign base17 = 17'(signed'(base_q));
	assign lsum   = base17 - turn;
	assign rsum   = base17 + turn;
	assign lim    = 17'(SPEED_LIMIT);

	function automatic logic [9:0] sat10(input logic signed [16:0] v,
	                                     input logic signed [16:0] l);
		logic signed [16:0] r;
		begin
			if (v > l)
				r = l;
			else if (v < -l)
				r = -l;
			else
				r = v;
			return r[9:0];
		end
	endfunction

	ddo_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((op == ddo_pkg::OP_ANGLE) || (op == ddo_pkg::OP_CMP && !reached)),
		.vec    (op == ddo_pkg::OP_CMP),
		.angle  (mid),
		.x_in   (ex_q),
		.y_in   (ey_q),
		.done   (status.cordic_done),
		.x_out  (cx),
		.y_out  (cy),
		.z_out  (cz)
	);

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_l_q  <= '0;
			last_r_q  <= '0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= '0;
			goal_q    <= '0;
		end else begin
			case (op)
				ddo_pkg::OP_LOAD: begin
					last_l_q <= in_data[15:0];
					last_r_q <= in_data[31:16];
				end
				ddo_pkg::OP_ANGLE: heading_q <= heading_q + dth;
				ddo_pkg::OP_MUL_Y: pos_x_q   <= pos_x_q + prod_q[61:30];
				ddo_pkg::OP_POSY:  pos_y_q   <= pos_y_q + prod_q[61:30];
				ddo_pkg::OP_CMP: begin
					if (reached)
						goal_q <= goal_inc;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			ddo_pkg::OP_LOAD: begin
				sneg_q    <= sum[16];
				smag_q    <= sum[16] ? 17'(-sum) : 17'(sum);
				dneg_q    <= dif[16];
				dmag_q    <= dif[16] ? 17'(-dif) : 17'(dif);
				lsp_q     <= '0;
				rsp_q     <= '0;
				reached_q <= 1'b0;
				done_q    <= 1'b0;
			end
			ddo_pkg::OP_MUL_D:
				ds_q <= sneg_q ? -33'(prod_q[40:9]) : 33'(prod_q[40:9]);
			ddo_pkg::OP_GOAL: begin
				ex_q <= gx - 33'(signed'(pos_x_q));
				ey_q <= gy - 33'(signed'(pos_y_q));
				if (no_goal)
					done_q <= 1'b1;
			end
			ddo_pkg::OP_MUL_EY: d2_q <= prod_q[50:0];
			ddo_pkg::OP_MUL_R:  d2_q <= d2_q + prod_q[50:0];
			ddo_pkg::OP_CMP: begin
				if (reached) begin
					reached_q <= 1'b1;
					done_q    <= goal_inc >= count;
				end
			end
			ddo_pkg::OP_ERR: begin
				eneg_q <= err[31];
				em_q   <= err[31] ? (32'd0 - err) : err;
			end
			ddo_pkg::OP_TURN: begin
				lsp_q <= sat10(lsum, lim);
				rsp_q <= sat10(rsum, lim);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (op == ddo_pkg::OP_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (op == ddo_pkg::OP_OUT)
			out_q <= {7'b0, done_q, reached_q, goal_q, heading_q, pos_y_q, pos_x_q,
			          rsp_q, lsp_q};
	end

	assign status.no_goal  = no_goal;
	assign status.reached  = reached;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

FILE: rtl/ddo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_ctrl: sequencing state machine
// Steps one encoder sample through the datapath operations and waits on
// the CORDIC unit and the output register.
// ----------------------------------------------------------------------------
module ddo_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ddo_pkg::status_t status,
	output ddo_pkg::cmd_t    cmd
);

	typedef enum logic [18:0] {
		S_IDLE    = 19'h00001,
		S_MUL_S   = 19'h00002,
		S_MUL_D   = 19'h00004,
		S_MUL_A   = 19'h00008,
		S_ANGLE   = 19'h00010,
		S_SC_WAIT = 19'h00020,
		S_MUL_X   = 19'h00040,
		S_MUL_Y   = 19'h00080,
		S_POSY    = 19'h00100,
		S_GOAL    = 19'h00200,
		S_MUL_EX  = 19'h00400,
		S_MUL_EY  = 19'h00800,
		S_MUL_R   = 19'h01000,
		S_CMP     = 19'h02000,
		S_AT_WAIT = 19'h04000,
		S_ERR     = 19'h08000,
		S_MUL_T   = 19'h10000,
		S_TURN    = 19'h20000,
		S_OUT     = 19'h40000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = ddo_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = ddo_pkg::OP_LOAD;
					state_d = S_MUL_S;
				end
			end
			S_MUL_S: begin
				cmd.op  = ddo_pkg::OP_MUL_S;
				state_d = S_MUL_D;
			end
			S_MUL_D: begin
				cmd.op  = ddo_pkg::OP_MUL_D;
				state_d = S_MUL_A;
			end
			S_MUL_A: begin
				cmd.op  = ddo_pkg::OP_MUL_A;
				state_d = S_ANGLE;
			end
			S_ANGLE: begin
				cmd.op  = ddo_pkg::OP_ANGLE;
				state_d = S_SC_WAIT;
			end
			S_SC_WAIT: begin
				if (status.cordic_done)
					state_d = S_MUL_X;
			end
			S_MUL_X: begin
				cmd.op  = ddo_pkg::OP_MUL_X;
				state_d = S_MUL_Y;
			end
			S_MUL_Y: begin
				cmd.op  = ddo_pkg::OP_MUL_Y;
				state_d = S_POSY;
			end
			S_POSY: begin
				cmd.op  = ddo_pkg::OP_POSY;
				state_d = S_GOAL;
			end
			S_GOAL: begin
				cmd.op  = ddo_pkg::OP_GOAL;
				state_d = status.no_goal ? S_OUT : S_MUL_EX;
			end
			S_MUL_EX: begin
				cmd.op  = ddo_pkg::OP_MUL_EX;
				state_d = S_MUL_EY;
			end
			S_MUL_EY: begin
				cmd.op  = ddo_pkg::OP_MUL_EY;
				state_d = S_MUL_R;
			end
			S_MUL_R: begin
				cmd.op  = ddo_pkg::OP_MUL_R;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = ddo_pkg::OP_CMP;
				state_d = status.reached ? S_OUT : S_AT_WAIT;
			end
			S_AT_WAIT: begin
				if (status.cordic_done)
					state_d = S_ERR;
			end
			S_ERR: begin
				cmd.op  = ddo_pkg::OP_ERR;
				state_d = S_MUL_T;
			end
			S_MUL_T: begin
				cmd.op  = ddo_pkg::OP_MUL_T;
				state_d = S_TURN;
			end
			S_TURN: begin
				cmd.op  = ddo_pkg::OP_TURN;
				state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.op  = ddo_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

FILE: rtl/diff_drive_odometry_goal_seek_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_goal_seek_top: wheel odometry with go-to-goal steering
// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid/s_axis_tready    encoder counts
// m_axis      out  m_axis_tvalid/m_axis_tready    speeds, pose, goal status
// cfg         in   cfg_we                         cfg_index, cfg_data
//
// While seeking, a sample makes two CORDIC passes, which dominate its time;
// once a goal is reached or none is left, it finishes sooner. A finished
// transfer waits in the output register while the next sample is taken; a
// stalled output holds the last state until free.
// Reset clears the pose, goal index and control; no clearing pass.
// ----------------------------------------------------------------------------
module diff_drive_odometry_goal_seek_top #(
	parameter int GOAL_SLOTS   = 4,
	parameter int CORDIC_STEPS = 16,
	parameter int SPEED_LIMIT  = 400
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // count_left, count_right
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // left_speed, right_speed, pos_x_out,
	                                    // pos_y_out, heading_out, goal_now,
	                                    // goal_reached, all_done
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	ddo_pkg::cmd_t    cmd;
	ddo_pkg::status_t status;

	ddo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ddo_datapath #(
		.GOAL_SLOTS  (GOAL_SLOTS),
		.CORDIC_STEPS(CORDIC_STEPS),
		.SPEED_LIMIT (SPEED_LIMIT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: bench/tb_diff_drive_odometry_goal_seek_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_goal_seek_top: self-checking bench for the odometry
// and goal-seek block
// Encoder samples are queued by a sequencer, driven on the input stream with
// random gaps and checked against a cycle-free pose and steering predictor
// on the output stream. Registers change between phases while idle.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry_goal_seek_top;

	localparam int STALL_LIMIT  = 20000;
	localparam int SETTLE       = 120;
	localparam int CORDIC_ITERS = 16;

	typedef struct packed {
		logic [6:0]  pad;
		logic        all_done;
		logic        goal_reached;
		logic [2:0]  goal_now;
		logic [31:0] heading;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
		logic [9:0]  right_speed;
		logic [9:0]  left_speed;
	} odo_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;

	diff_drive_odometry_goal_seek_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor copy of registers and state
	logic [23:0] p_dist_per_tick;
	logic [31:0] p_angle_per_cm;
	logic [15:0] p_kp;
	logic [9:0]  p_base;
	logic [15:0] p_radius;
	logic [2:0]  p_goal_count;
	logic [63:0] p_goal_x, p_goal_y;
	logic [15:0] p_last_l = '0, p_last_r = '0;
	logic [31:0] p_x = '0, p_y = '0, p_heading = '0;
	logic [2:0]  p_goal_idx = '0;

	logic [31:0] atan_lut [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	logic [31:0]  sample_q [$];
	odo_result_t  pose_q [$];
	bit           failed = 1'b0;
	bit           quiet = 1'b0;
	bit           in_acc = 1'b0;
	int           tx_gap = 0;
	int           rx_gap = 0;
	int           hold_req = 0, hold_seen = 0, hold_cnt = 0;
	int           idle_cycles = 0;

	task automatic rotate_vec(input logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, tx, ty;
		logic [31:0] a;
		bit flip;
		a = ang;
		flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		if (flip)
			a = a + 32'h8000_0000;
		x = longint'(ddo_pkg::CORDIC_GAIN_Q30);
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			tx = y >>> i;
			ty = x >>> i;
			if (z >= 0) begin
				x -= tx; y += ty; z -= longint'(atan_lut[i]);
			end else begin
				x += tx; y -= ty; z += longint'(atan_lut[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic logic [31:0] bearing(input longint xi, input longint yi);
		longint x, y, tx, ty;
		logic [31:0] z;
		x = xi;
		y = yi;
		z = '0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			tx = y >>> i;
			ty = x >>> i;
			if (y >= 0) begin
				x += tx; y -= ty; z += atan_lut[i];
			end else begin
				x -= tx; y += ty; z -= atan_lut[i];
			end
		end
		return z;
	endfunction

	function automatic longint clamp_speed(input longint v);
		if (v > 400)
			return 400;
		if (v < -400)
			return -400;
		return v;
	endfunction

	task automatic predict_pose(input logic [31:0] sample);
		logic [15:0] d16l, d16r;
		longint dl, dr, sum, dif, ds, c, s, gx, gy, ex, ey, ex8, ey8, d2, r2;
		longint err, turn, base, lsp, rsp;
		logic [63:0] smag, dmag, ang, em, tq;
		logic [31:0] dth, hth, mid, target;
		logic [2:0] used;
		odo_result_t r;
		d16l = sample[15:0] - p_last_l;
		d16r = sample[31:16] - p_last_r;
		dl = longint'($signed(d16l));
		dr = longint'($signed(d16r));
		p_last_l = sample[15:0];
		p_last_r = sample[31:16];
		sum = dl + dr;
		dif = dr - dl;
		smag = (sum < 0) ? -sum : sum;
		smag = (smag * {40'b0, p_dist_per_tick}) >> 9;
		ds = (sum < 0) ? -longint'(smag) : longint'(smag);
		dmag = (dif < 0) ? -dif : dif;
		dmag = (dmag * {40'b0, p_dist_per_tick}) >> 8;
		ang = (dmag * {32'b0, p_angle_per_cm}) >> 16;
		dth = ang[31:0];
		hth = ang[32:1];
		if (dif < 0) begin
			dth = -dth; hth = -hth;
		end
		mid = p_heading + hth;
		p_heading = p_heading + dth;
		rotate_vec(mid, c, s);
		p_x = p_x + 32'((ds * c) >>> 30);
		p_y = p_y + 32'((ds * s) >>> 30);
		used = (p_goal_count > 3'd4) ? 3'd4 : p_goal_count;
		r = '0;
		lsp = 0;
		rsp = 0;
		if (p_goal_idx >= used) begin
			r.all_done = 1'b1;
		end else begin
			gx = longint'($signed(p_goal_x[16*p_goal_idx[1:0] +: 16])) * 512;
			gy = longint'($signed(p_goal_y[16*p_goal_idx[1:0] +: 16])) * 512;
			ex = gx - longint'($signed(p_x));
			ey = gy - longint'($signed(p_y));
			ex8 = ex >>> 8;
			ey8 = ey >>> 8;
			d2 = ex8 * ex8 + ey8 * ey8;
			r2 = longint'(p_radius) * longint'(p_radius);
			if (d2 > r2) begin
				target = bearing(ex, ey);
				err = longint'($signed(target - p_heading));
				em = (err < 0) ? -err : err;
				tq = (em * {48'b0, p_kp} * 64'd25736) >> 52;
				turn = (err < 0) ? -longint'(tq) : longint'(tq);
				base = longint'($signed(p_base));
				lsp = clamp_speed(base - turn);
				rsp = clamp_speed(base + turn);
			end else begin
				r.goal_reached = 1'b1;
				p_goal_idx = p_goal_idx + 3'd1;
				r.all_done = (p_goal_idx >= used);
			end
		end
		r.left_speed = lsp[9:0];
		r.right_speed = rsp[9:0];
		r.pos_x = p_x;
		r.pos_y = p_y;
		r.heading = p_heading;
		r.goal_now = p_goal_idx;
		pose_q.push_back(r);
	endtask

	// input stream: hold data until transfer, then advance or gap
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_acc)) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				s_axis_tdata <= sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					tx_gap <= $urandom_range(1, 18);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output stream: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= 700;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n;
			if (!quiet && $urandom_range(0, 9) == 0)
				rx_gap <= $urandom_range(1, 18);
		end
	end

	always @(posedge clk) begin
		odo_result_t got, want;
		in_acc <= s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			got = odo_result_t'(m_axis_tdata);
			if (pose_q.size() == 0) begin
				$error("result transfer with nothing expected");
				failed = 1'b1;
			end else begin
				want = pose_q.pop_front();
				if (got.left_speed !== want.left_speed) begin
					$error("left_speed exp %0d got %0d", want.left_speed, got.left_speed);
					failed = 1'b1;
				end
				if (got.right_speed !== want.right_speed) begin
					$error("right_speed exp %0d got %0d", want.right_speed, got.right_speed);
					failed = 1'b1;
				end
				if (got.pos_x !== want.pos_x) begin
					$error("pos_x_out exp %h got %h", want.pos_x, got.pos_x);
					failed = 1'b1;
				end
				if (got.pos_y !== want.pos_y) begin
					$error("pos_y_out exp %h got %h", want.pos_y, got.pos_y);
					failed = 1'b1;
				end
				if (got.heading !== want.heading) begin
					$error("heading_out exp %h got %h", want.heading, got.heading);
					failed = 1'b1;
				end
				if (got.goal_now !== want.goal_now) begin
					$error("goal_now exp %0d got %0d", want.goal_now, got.goal_now);
					failed = 1'b1;
				end
				if (got.goal_reached !== want.goal_reached) begin
					$error("goal_reached exp %0d got %0d", want.goal_reached,
						got.goal_reached);
					failed = 1'b1;
				end
				if (got.all_done !== want.all_done) begin
					$error("all_done exp %0d got %0d", want.all_done, got.all_done);
					failed = 1'b1;
				end
				if (got.pad !== '0) begin
					$error("tdata padding exp 0 got %h", got.pad);
					failed = 1'b1;
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready)
			predict_pose(s_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (sample_q.size() == 0 && !s_axis_tvalid && pose_q.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input ddo_pkg::cfg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			ddo_pkg::CFG_DIST_PER_TICK: p_dist_per_tick = val[23:0];
			ddo_pkg::CFG_ANGLE_PER_CM:  p_angle_per_cm = val[31:0];
			ddo_pkg::CFG_KP_ANGLE:      p_kp = val[15:0];
			ddo_pkg::CFG_BASE_SPEED:    p_base = val[9:0];
			ddo_pkg::CFG_ARRIVE_RADIUS: p_radius = val[15:0];
			ddo_pkg::CFG_GOAL_COUNT:    p_goal_count = val[2:0];
			ddo_pkg::CFG_GOAL_X_TABLE:  p_goal_x = val;
			ddo_pkg::CFG_GOAL_Y_TABLE:  p_goal_y = val;
		endcase
	endtask

	function automatic logic [31:0] pick32(input logic [31:0] hi);
		int k;
		k = $urandom_range(0, 5);
		if (k == 0)
			return '0;
		if (k == 1)
			return hi;
		return $urandom() & hi;
	endfunction

	task automatic retune(input logic [2:0] goals, input logic [15:0] radius);
		int bs;
		case ($urandom_range(0, 4))
			0: bs = -400;
			1: bs = 400;
			default: bs = $urandom_range(0, 800) - 400;
		endcase
		write_reg(ddo_pkg::CFG_DIST_PER_TICK, 64'(pick32(32'hFF_FFFF)));
		write_reg(ddo_pkg::CFG_ANGLE_PER_CM, 64'(pick32(32'hFFFF_FFFF)));
		write_reg(ddo_pkg::CFG_KP_ANGLE, 64'(pick32(32'hFFFF)));
		write_reg(ddo_pkg::CFG_BASE_SPEED, 64'(bs[9:0]));
		write_reg(ddo_pkg::CFG_ARRIVE_RADIUS, 64'(radius));
		write_reg(ddo_pkg::CFG_GOAL_COUNT, 64'(goals));
		write_reg(ddo_pkg::CFG_GOAL_X_TABLE, {$urandom(), $urandom()});
		write_reg(ddo_pkg::CFG_GOAL_Y_TABLE, {$urandom(), $urandom()});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		wait (sample_q.size() == 0 && !s_axis_tvalid && pose_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [15:0] cl, cr;
		logic [2:0]  goals;
		logic [15:0] radius;
		p_dist_per_tick = 24'd185406;
		p_angle_per_cm = 32'd80419640;
		p_kp = 16'd7680;
		p_base = 10'd75;
		p_radius = 16'd256;
		p_goal_count = 3'd3;
		p_goal_x = 64'd125832960;
		p_goal_y = 64'd503320320;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero motion, full-scale wraps both ways, pure turns
		sample_q.push_back({16'd0, 16'd0});
		sample_q.push_back({16'd1, 16'd1});
		sample_q.push_back({16'd0, 16'd0});
		sample_q.push_back({16'h7FFF, 16'h7FFF});
		sample_q.push_back({16'hFFFF, 16'hFFFF});
		sample_q.push_back({16'h7FFF, 16'h8000});
		sample_q.push_back({16'h8000, 16'h7FFF});
		sample_q.push_back({16'd100, 16'hFF9C});
		sample_q.push_back({16'hFF9C, 16'd100});
		sample_q.push_back({16'h0000, 16'hFFFF});
		sample_q.push_back({16'h1234, 16'h1234});
		sample_q.push_back({16'h1334, 16'h1300});
		drain();
		// no goals: counts as done at once
		retune(3'd0, 16'd100);
		sample_q.push_back({16'h1400, 16'h1400});
		sample_q.push_back({16'h1500, 16'h1480});
		drain();

		cl = '0;
		cr = '0;
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 7) begin
				goals = 3'($urandom_range(2, 7));
				radius = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 400));
			end else if (ph == 7) begin
				goals = 3'($urandom_range(1, 7));
				radius = 16'($urandom());
			end else begin
				goals = (ph == 8) ? 3'd4 : 3'd7;
				radius = 16'hFFFF;
			end
			quiet = (ph == 9);
			retune(goals, radius);
			for (int n = 0; n < 125; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					cl = 16'($urandom());
					cr = 16'($urandom());
				end else begin
					cl = cl + 16'($urandom_range(0, 600) - 300);
					cr = cr + 16'($urandom_range(0, 600) - 300);
				end
				sample_q.push_back({cr, cl});
			end
			if (ph == 3)
				hold_req = hold_req + 1;
			drain();
		end

		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
